// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ----- rtl/tvac_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvac_pkg
// Codes, widths and command types of the vent actuator controller.
// ----------------------------------------------------------------------------
package tvac_pkg;

  localparam int POS_W  = 24;
  localparam int TIME_W = 16;
  localparam int WIN_W  = 4;
  localparam int CFG_W  = 24;

  localparam logic [POS_W-1:0] POS_RESET = 24'd60000;

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_OPEN  = 2'd1;
  localparam logic [1:0] ACT_CLOSE = 2'd2;
  localparam logic [1:0] ACT_QUERY = 2'd3;

  localparam logic CFG_FULL_OPEN   = 1'b0;
  localparam logic CFG_RELAY_LEVEL = 1'b1;

  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_REQ  = 2'd2;

  typedef struct packed {
    logic       capture;
    logic [1:0] op;
    logic       last;
  } ctl_cmd_t;

endpackage

// ----- rtl/tvac_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvac_ctrl
// Sequencer: takes a transaction and steps the datapath over the windows.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tvac_ctrl #(
  parameter int WINDOW_COUNT = 4,
  parameter int IDX_W        = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [1:0]           action,
  output logic                 busy,
  output tvac_pkg::ctl_cmd_t   cmd,
  output logic [IDX_W-1:0]     idx
);
  import tvac_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_TICK = 2'd1;
  localparam logic [1:0] S_REQ  = 2'd2;

  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(WINDOW_COUNT - 1);

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [IDX_W-1:0] cnt;
  logic [IDX_W-1:0] cnt_next;

  assign busy = (state != S_IDLE);
  assign idx  = cnt;

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    cmd.capture = 1'b0;
    cmd.op      = OP_NONE;
    cmd.last    = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          cnt_next    = '0;
          state_next  = (action == ACT_TICK) ? S_TICK : S_REQ;
        end
      end
      S_TICK: begin
        cmd.op = OP_TICK;
        if (cnt == IDX_MAX) begin
          cmd.last   = 1'b1;
          state_next = S_IDLE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_REQ: begin
        cmd.op     = OP_REQ;
        cmd.last   = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  `ASSERT_SAME(a_op_busy, clk, rst, cmd.op != OP_NONE, busy, "step issued while idle")
  `ASSERT_NEXT(a_last_idle, clk, rst, cmd.last, !busy, "sequence did not end after last step")
  `ASSERT_SAME(a_capture_idle, clk, rst, cmd.capture, !busy && start, "capture outside accept")
  `ASSERT_NEXT(a_tick_adv, clk, rst, cmd.op == OP_TICK && !cmd.last,
               cmd.op == OP_TICK && cnt == $past(cnt) + 1'b1, "window sweep skipped")
endmodule

// ----- rtl/tvac_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvac_datapath
// Per-window state, tick update, move request check and result register.
// ----------------------------------------------------------------------------
module tvac_datapath #(
  parameter int WINDOW_COUNT = 4,
  parameter int IDX_W        = 2
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tvac_pkg::ctl_cmd_t            cmd,
  input  logic [IDX_W-1:0]              idx,
  input  logic [1:0]                    action,
  input  logic [tvac_pkg::WIN_W-1:0]    window_index,
  input  logic [tvac_pkg::POS_W-1:0]    target_position,
  input  logic [tvac_pkg::TIME_W-1:0]   elapsed_time,
  input  logic                          cfg_write,
  input  logic                          cfg_index,
  input  logic [tvac_pkg::CFG_W-1:0]    cfg_data,
  output logic                          strobe,
  output logic [tvac_pkg::WIN_W-1:0]    window_number,
  output logic                          accepted,
  output logic                          relay_open_drive,
  output logic                          relay_close_drive,
  output logic                          moving,
  output logic                          moving_open,
  output logic                          arrived,
  output logic [tvac_pkg::POS_W-1:0]    position_now,
  output logic                          last
);
  import tvac_pkg::*;

  localparam logic [WIN_W:0] WIN_LIMIT = (WIN_W + 1)'(WINDOW_COUNT);

  logic [POS_W-1:0] position    [WINDOW_COUNT];
  logic [POS_W-1:0] target      [WINDOW_COUNT];
  logic [POS_W-1:0] run_length  [WINDOW_COUNT];
  logic [POS_W-1:0] run_elapsed [WINDOW_COUNT];
  logic             dir_open    [WINDOW_COUNT];
  logic             win_busy    [WINDOW_COUNT];
  logic             driving     [WINDOW_COUNT];

  logic [1:0]        in_action;
  logic [WIN_W-1:0]  in_window;
  logic [POS_W-1:0]  in_target;
  logic [TIME_W-1:0] in_elapsed;
  logic              level_on;

  logic [IDX_W-1:0]  rd;
  logic              present;
  logic [POS_W:0]    sum;
  logic [POS_W-1:0]  sum_sat;
  logic              want_open;
  logic              is_req;
  logic              req_ok;
  logic [POS_W-1:0]  hi;
  logic [POS_W-1:0]  lo;

  logic              wr;
  logic              arr;
  logic              acc;
  logic [POS_W-1:0]  pos_next;
  logic [POS_W-1:0]  tgt_next;
  logic [POS_W-1:0]  len_next;
  logic [POS_W-1:0]  el_next;
  logic              dir_next;
  logic              busy_next;
  logic              drv_next;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_action  <= action;
      in_window  <= window_index;
      in_target  <= target_position;
      in_elapsed <= elapsed_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level_on <= 1'b0;
    end else if (cfg_write && cfg_index == CFG_RELAY_LEVEL) begin
      level_on <= cfg_data[0];
    end
  end

  assign rd        = (cmd.op == OP_TICK) ? idx : in_window[IDX_W-1:0];
  assign present   = (cmd.op == OP_TICK) || ({1'b0, in_window} < WIN_LIMIT);
  assign sum       = {1'b0, run_elapsed[rd]} + (POS_W + 1)'(in_elapsed);
  assign sum_sat   = sum[POS_W] ? {POS_W{1'b1}} : sum[POS_W-1:0];
  assign want_open = (in_action == ACT_OPEN);
  assign is_req    = (in_action == ACT_OPEN) || (in_action == ACT_CLOSE);
  assign hi        = want_open ? in_target : position[rd];
  assign lo        = want_open ? position[rd] : in_target;
  assign req_ok    = is_req && present && !win_busy[rd] && (hi > lo);

  always_comb begin
    wr        = 1'b0;
    arr       = 1'b0;
    acc       = 1'b0;
    pos_next  = position[rd];
    tgt_next  = target[rd];
    len_next  = run_length[rd];
    el_next   = run_elapsed[rd];
    dir_next  = dir_open[rd];
    busy_next = win_busy[rd];
    drv_next  = driving[rd];
    case (cmd.op)
      OP_TICK: begin
        wr = 1'b1;
        if (!win_busy[rd]) begin
          drv_next = 1'b0;
        end else if (sum_sat >= run_length[rd]) begin
          pos_next  = target[rd];
          len_next  = '0;
          el_next   = '0;
          busy_next = 1'b0;
          drv_next  = 1'b0;
          arr       = 1'b1;
        end else begin
          el_next  = sum_sat;
          drv_next = 1'b1;
        end
      end
      OP_REQ: begin
        if (req_ok) begin
          wr        = 1'b1;
          acc       = 1'b1;
          len_next  = hi - lo;
          el_next   = '0;
          tgt_next  = in_target;
          dir_next  = want_open;
          busy_next = 1'b1;
        end
      end
      default: begin
        wr = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW_COUNT; i++) begin
        position[i]    <= POS_RESET;
        target[i]      <= '0;
        run_length[i]  <= POS_RESET;
        run_elapsed[i] <= '0;
        dir_open[i]    <= 1'b0;
        win_busy[i]    <= 1'b1;
        driving[i]     <= 1'b0;
      end
    end else if (wr) begin
      position[rd]    <= pos_next;
      target[rd]      <= tgt_next;
      run_length[rd]  <= len_next;
      run_elapsed[rd] <= el_next;
      dir_open[rd]    <= dir_next;
      win_busy[rd]    <= busy_next;
      driving[rd]     <= drv_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
      last   <= 1'b0;
    end else begin
      strobe <= (cmd.op != OP_NONE);
      last   <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op != OP_NONE) begin
      window_number     <= (cmd.op == OP_TICK) ? WIN_W'(idx) : in_window;
      accepted          <= acc;
      arrived           <= arr;
      relay_open_drive  <= (present && drv_next && dir_next) ? level_on : ~level_on;
      relay_close_drive <= (present && drv_next && !dir_next) ? level_on : ~level_on;
      moving            <= present && busy_next;
      moving_open       <= present && busy_next && dir_next;
      position_now      <= present ? pos_next : '0;
    end
  end
endmodule

// ----- rtl/timed_vent_actuator_control.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_vent_actuator_control
// Run-time vent motor controller with per-window relay pair drive.
// ----------------------------------------------------------------------------
// Tick: WINDOW_COUNT results on consecutive cycles, one per window in the sequencer's sweep.
// Request or query: one result. Each result is registered after the sequencer step that makes it.
// A new start is taken only while idle, after the sweep or request step ends; busy is high meanwhile.
// Results are strobed for one cycle; the receiver cannot stall.
// Synchronous reset: all windows closing from 60000 toward 0, relays off.
module timed_vent_actuator_control #(
  parameter int WINDOW_COUNT = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    action,
  input  logic [tvac_pkg::WIN_W-1:0]    window_index,
  input  logic [tvac_pkg::POS_W-1:0]    target_position,
  input  logic [tvac_pkg::TIME_W-1:0]   elapsed_time,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [tvac_pkg::CFG_W-1:0]    cfg_data,
  output logic                          strobe,
  output logic [tvac_pkg::WIN_W-1:0]    window_number,
  output logic                          accepted,
  output logic                          relay_open_drive,
  output logic                          relay_close_drive,
  output logic                          moving,
  output logic                          moving_open,
  output logic                          arrived,
  output logic [tvac_pkg::POS_W-1:0]    position_now,
  output logic                          last
);
  import tvac_pkg::*;

  localparam int IDX_W = (WINDOW_COUNT > 1) ? $clog2(WINDOW_COUNT) : 1;

  ctl_cmd_t         cmd;
  logic [IDX_W-1:0] idx;

  assign cfg_ready = !busy;

  tvac_ctrl #(
    .WINDOW_COUNT(WINDOW_COUNT),
    .IDX_W       (IDX_W)
  ) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .action(action),
    .busy  (busy),
    .cmd   (cmd),
    .idx   (idx)
  );

  tvac_datapath #(
    .WINDOW_COUNT(WINDOW_COUNT),
    .IDX_W       (IDX_W)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .idx              (idx),
    .action           (action),
    .window_index     (window_index),
    .target_position  (target_position),
    .elapsed_time     (elapsed_time),
    .cfg_write        (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .strobe           (strobe),
    .window_number    (window_number),
    .accepted         (accepted),
    .relay_open_drive (relay_open_drive),
    .relay_close_drive(relay_close_drive),
    .moving           (moving),
    .moving_open      (moving_open),
    .arrived          (arrived),
    .position_now     (position_now),
    .last             (last)
  );
endmodule

// ----- tb/tb_timed_vent_actuator_control.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_timed_vent_actuator_control
// Self-checking bench for the vent actuator controller. A queue-fed driver
// issues ticks, open and close requests and status queries with random gaps.
// A monitor keeps its own model of every window (position, run time, relay
// drive) and checks each strobed status transaction against it, in order.
// Stimulus runs a directed opening, a long saturating run, then random move
// sequences under several relay level and full-open settings.
// ----------------------------------------------------------------------------
module tb_timed_vent_actuator_control;
  import tvac_pkg::*;

  localparam int NWIN = 4;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
  localparam logic [TIME_W-1:0] DT_MAX = {TIME_W{1'b1}};
  localparam int RANDOM_ITEMS = 160;
  localparam int PHASES = 4;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic [1:0]        action;
    logic [WIN_W-1:0]  win;
    logic [POS_W-1:0]  tgt;
    logic [TIME_W-1:0] dt;
  } vent_cmd_t;

  typedef struct {
    logic [WIN_W-1:0] win;
    logic             acc;
    logic             ropen;
    logic             rclose;
    logic             mov;
    logic             mov_open;
    logic             arr;
    logic [POS_W-1:0] pos;
    logic             fin;
  } vent_status_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] action = ACT_TICK;
  logic [WIN_W-1:0] window_index = '0;
  logic [POS_W-1:0] target_position = '0;
  logic [TIME_W-1:0] elapsed_time = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = CFG_FULL_OPEN;
  logic [CFG_W-1:0] cfg_data = '0;
  logic strobe;
  logic [WIN_W-1:0] window_number;
  logic accepted;
  logic relay_open_drive;
  logic relay_close_drive;
  logic moving;
  logic moving_open;
  logic arrived;
  logic [POS_W-1:0] position_now;
  logic last;

  vent_cmd_t cmd_q[$];
  vent_status_t status_q[$];
  logic took_item = 1'b0;
  int gap_left = 0;
  int burst_left = 0;
  int err_cnt = 0;
  int n_pushed = 0;
  int cycle_cnt = 0;

  logic [POS_W-1:0] win_pos [NWIN];
  logic [POS_W-1:0] win_goal [NWIN];
  logic [POS_W-1:0] win_span [NWIN];
  logic [POS_W-1:0] win_run [NWIN];
  logic win_dir_open [NWIN];
  logic win_busy [NWIN];
  logic win_drive [NWIN];
  logic level_on;
  logic [CFG_W-1:0] full_open_reg;

  timed_vent_actuator_control #(
    .WINDOW_COUNT(NWIN)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .action(action),
    .window_index(window_index),
    .target_position(target_position),
    .elapsed_time(elapsed_time),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .strobe(strobe),
    .window_number(window_number),
    .accepted(accepted),
    .relay_open_drive(relay_open_drive),
    .relay_close_drive(relay_close_drive),
    .moving(moving),
    .moving_open(moving_open),
    .arrived(arrived),
    .position_now(position_now),
    .last(last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_timed_vent_actuator_control NOT OK");
      $finish;
    end
  end

  task automatic log_error(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  task automatic check_field(logic [WIN_W-1:0] w, string name, logic [POS_W-1:0] got,
                             logic [POS_W-1:0] want);
    if (got !== want)
      log_error($sformatf("window %0d %s got %0h want %0h", w, name, got, want));
  endtask

  function automatic vent_status_t window_status(int w, logic acc, logic arr, logic fin);
    vent_status_t s;
    logic off;
    off = ~level_on;
    s.win = w[WIN_W-1:0];
    s.acc = acc;
    s.fin = fin;
    s.ropen = off;
    s.rclose = off;
    s.mov = 1'b0;
    s.mov_open = 1'b0;
    s.arr = 1'b0;
    s.pos = '0;
    if (w < NWIN) begin
      s.ropen = (win_drive[w] && win_dir_open[w]) ? level_on : off;
      s.rclose = (win_drive[w] && !win_dir_open[w]) ? level_on : off;
      s.mov = win_busy[w];
      s.mov_open = win_busy[w] && win_dir_open[w];
      s.arr = arr;
      s.pos = win_pos[w];
    end
    return s;
  endfunction

  // Advance the window model by one command and queue the status it causes.
  function automatic void vent_predict(vent_cmd_t c);
    logic [POS_W:0] sum;
    logic arr;
    logic acc;
    int w;
    int i;
    if (c.action == ACT_TICK) begin
      for (i = 0; i < NWIN; i++) begin
        arr = 1'b0;
        if (!win_busy[i]) begin
          win_drive[i] = 1'b0;
        end else begin
          sum = {1'b0, win_run[i]} + c.dt;
          if (sum > POS_MAX) sum = POS_MAX;
          win_run[i] = sum[POS_W-1:0];
          if (win_run[i] >= win_span[i]) begin
            win_pos[i] = win_goal[i];
            win_span[i] = '0;
            win_run[i] = '0;
            win_busy[i] = 1'b0;
            win_drive[i] = 1'b0;
            arr = 1'b1;
          end else begin
            win_drive[i] = 1'b1;
          end
        end
        status_q.push_back(window_status(i, 1'b0, arr, i == NWIN - 1));
      end
    end else begin
      w = c.win;
      acc = 1'b0;
      if (w < NWIN && c.action != ACT_QUERY && !win_busy[w] && c.tgt != win_pos[w] &&
          ((c.action == ACT_OPEN) == (c.tgt > win_pos[w]))) begin
        acc = 1'b1;
        win_span[w] = (c.action == ACT_OPEN) ? c.tgt - win_pos[w] : win_pos[w] - c.tgt;
        win_run[w] = '0;
        win_goal[w] = c.tgt;
        win_dir_open[w] = (c.action == ACT_OPEN);
        win_busy[w] = 1'b1;
      end
      status_q.push_back(window_status(w, acc, 1'b0, 1'b1));
    end
  endfunction

  always @(posedge clk) begin
    vent_cmd_t c;
    vent_status_t want;
    took_item <= start && !busy && !rst;
    if (rst) begin
      level_on = 1'b0;
      full_open_reg = POS_RESET;
      for (int i = 0; i < NWIN; i++) begin
        win_pos[i] = POS_RESET;
        win_goal[i] = '0;
        win_span[i] = POS_RESET;
        win_run[i] = '0;
        win_dir_open[i] = 1'b0;
        win_busy[i] = 1'b1;
        win_drive[i] = 1'b0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_FULL_OPEN) full_open_reg = cfg_data;
        else level_on = cfg_data[0];
      end
      if (start && !busy) begin
        c.action = action;
        c.win = window_index;
        c.tgt = target_position;
        c.dt = elapsed_time;
        vent_predict(c);
      end
      if (strobe) begin
        if (status_q.size() == 0) begin
          log_error($sformatf("unexpected status transaction for window %0d", window_number));
        end else begin
          want = status_q.pop_front();
          check_field(want.win, "window_number", window_number, want.win);
          check_field(want.win, "accepted", accepted, want.acc);
          check_field(want.win, "relay_open_drive", relay_open_drive, want.ropen);
          check_field(want.win, "relay_close_drive", relay_close_drive, want.rclose);
          check_field(want.win, "moving", moving, want.mov);
          check_field(want.win, "moving_open", moving_open, want.mov_open);
          check_field(want.win, "arrived", arrived, want.arr);
          check_field(want.win, "position_now", position_now, want.pos);
          check_field(want.win, "last", last, want.fin);
        end
      end
    end
  end

  always @(negedge clk) begin
    vent_cmd_t c;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || took_item) begin
      if (gap_left > 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (cmd_q.size() != 0) begin
        c = cmd_q.pop_front();
        action <= c.action;
        window_index <= c.win;
        target_position <= c.tgt;
        elapsed_time <= c.dt;
        start <= 1'b1;
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
          gap_left <= 0;
        end else begin
          gap_left <= $urandom_range(0, 8);
          if ($urandom_range(0, 15) == 0) burst_left <= $urandom_range(5, 30);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic push_cmd(logic [1:0] a, logic [WIN_W-1:0] w, logic [POS_W-1:0] t,
                          logic [TIME_W-1:0] d);
    vent_cmd_t c;
    c.action = a;
    c.win = w;
    c.tgt = t;
    c.dt = d;
    cmd_q.push_back(c);
    n_pushed++;
  endtask

  // Hold until every queued command has been taken by the block.
  task automatic wait_caught_up();
    do begin
      @(posedge clk);
      #1;
    end while (!(cmd_q.size() == 0 && (!start || took_item)));
  endtask

  task automatic wait_idle();
    wait_caught_up();
    while (status_q.size() != 0) begin
      @(posedge clk);
      #1;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Request a move, preferring a free window, then tick it toward its target.
  task automatic run_move();
    int w;
    int tries;
    int nticks;
    logic open_way;
    logic [POS_W-1:0] p;
    logic [POS_W-1:0] t;
    int unsigned travel;
    int unsigned remain;
    int unsigned step;
    wait_caught_up();
    w = $urandom_range(0, NWIN - 1);
    tries = 0;
    while (win_busy[w] && tries < 6) begin
      w = $urandom_range(0, NWIN - 1);
      tries++;
    end
    p = win_pos[w];
    open_way = (p == 0) ? 1'b1 : (p == POS_MAX) ? 1'b0 : 1'($urandom_range(0, 1));
    travel = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 200000) : $urandom_range(1, 2000);
    if (open_way) t = (POS_MAX - p < travel) ? POS_MAX : POS_W'(p + travel);
    else t = (p < travel) ? '0 : POS_W'(p - travel);
    travel = open_way ? t - p : p - t;
    push_cmd(open_way ? ACT_OPEN : ACT_CLOSE, w, t, $urandom);
    remain = travel;
    nticks = 0;
    while (remain > 0 && nticks < 10) begin
      if ($urandom_range(0, 3) == 0)
        push_cmd($urandom_range(ACT_OPEN, ACT_QUERY), w, $urandom, $urandom);
      if (remain > DT_MAX) step = $urandom_range(0, DT_MAX);
      else if ($urandom_range(0, 2) == 0) step = remain;
      else step = $urandom_range(0, remain);
      push_cmd(ACT_TICK, $urandom, $urandom, step);
      remain = (remain > step) ? remain - step : 0;
      nticks++;
    end
  endtask

  task automatic run_refusal();
    int w;
    logic [POS_W-1:0] p;
    wait_caught_up();
    w = $urandom_range(0, NWIN - 1);
    p = win_pos[w];
    case ($urandom_range(0, 2))
      0: begin
        push_cmd($urandom_range(ACT_OPEN, ACT_CLOSE), w, p, $urandom);
      end
      1: begin
        if (p != 0) push_cmd(ACT_OPEN, w, $urandom_range(0, p - 1), $urandom);
        else push_cmd(ACT_CLOSE, w, $urandom_range(1, POS_MAX), $urandom);
      end
      default: begin
        push_cmd(ACT_QUERY, $urandom, $urandom, $urandom);
      end
    endcase
  endtask

  initial begin
    int goal;
    int kind;
    int unsigned remain;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reset close, exact arrival, refusals, absent windows
    push_cmd(ACT_QUERY, 0, 0, 0);
    push_cmd(ACT_QUERY, 15, POS_MAX, DT_MAX);
    push_cmd(ACT_OPEN, 1, 70000, 0);
    push_cmd(ACT_TICK, 0, 0, 0);
    push_cmd(ACT_TICK, 0, 0, 59999);
    push_cmd(ACT_TICK, 0, 0, 1);
    push_cmd(ACT_TICK, 0, 0, DT_MAX);
    push_cmd(ACT_CLOSE, 0, 0, 0);
    push_cmd(ACT_CLOSE, 0, 5, 0);
    push_cmd(ACT_OPEN, 0, POS_MAX, 0);
    push_cmd(ACT_OPEN, 1, 1000, 0);
    push_cmd(ACT_OPEN, 2, 0, 0);
    push_cmd(ACT_OPEN, 9, 100, 0);
    push_cmd(ACT_QUERY, 3, 0, 0);
    push_cmd(ACT_TICK, 0, 0, 500);
    push_cmd(ACT_TICK, 0, 0, 500);
    push_cmd(ACT_OPEN, 1, 999, 0);
    push_cmd(ACT_CLOSE, 1, 999, 0);
    push_cmd(ACT_OPEN, 1, 5000, 0);
    push_cmd(ACT_CLOSE, 12, 0, 0);
    push_cmd(ACT_TICK, 0, 0, 1);
    push_cmd(ACT_QUERY, 1, 0, 0);
    push_cmd(ACT_QUERY, 0, 0, 0);

    // run window 0 to fully open with maximum ticks so the timer saturates
    wait_caught_up();
    remain = win_busy[0] ? win_span[0] - win_run[0] : 0;
    while (remain > 0) begin
      push_cmd(ACT_TICK, $urandom, $urandom, DT_MAX);
      remain = (remain > DT_MAX) ? remain - DT_MAX : 0;
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: begin
          write_reg(CFG_RELAY_LEVEL, 1);
          write_reg(CFG_FULL_OPEN, 1);
        end
        1: begin
          write_reg(CFG_RELAY_LEVEL, 0);
          write_reg(CFG_FULL_OPEN, POS_MAX);
        end
        2: begin
          write_reg(CFG_RELAY_LEVEL, 1);
          write_reg(CFG_FULL_OPEN, $urandom_range(1, POS_MAX));
        end
        default: begin
          write_reg(CFG_RELAY_LEVEL, 0);
          write_reg(CFG_FULL_OPEN, POS_RESET);
        end
      endcase
      goal = n_pushed + RANDOM_ITEMS / PHASES;
      while (n_pushed < goal) begin
        kind = $urandom_range(0, 9);
        if (kind < 6) run_move();
        else if (kind < 8) run_refusal();
        else if (kind == 8) push_cmd($urandom_range(0, 3), $urandom, $urandom, $urandom);
        else push_cmd(ACT_TICK, $urandom, $urandom, $urandom);
      end
    end

    wait_idle();
    if (err_cnt == 0) begin
      $display("tb_timed_vent_actuator_control OK");
    end else begin
      $display("tb_timed_vent_actuator_control NOT OK");
    end
    $finish;
  end

endmodule
